// ===== rtl/core/csp_pkg.sv =====
// ============================================================================
// csp_pkg
// Shared constants, register codes and pipeline payload types of the capsule
// support point block.
// ============================================================================
`default_nettype none

package csp_pkg;

    // Fixed-point formats.
    localparam int FRACTION_BITS = 16;
    localparam int UNIT_BITS     = 30;
    localparam int AXIS_BITS     = 14;
    localparam int COORD_W       = 32;
    localparam int AXIS_W        = 16;
    localparam int LEN_W         = 32;
    localparam int UMAG_W        = UNIT_BITS + 1;
    localparam int SR_W          = 33;

    // Iteration counts of the square root and divider pipelines.
    localparam int SQRT_STEPS    = LEN_W;
    localparam int DIV_STEPS     = UMAG_W;

    // Register port.
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    typedef enum logic [2:0] {
        REG_RADIUS,
        REG_HEIGHT,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z
    } reg_idx_t;

    // Static shape of the capsule.
    typedef struct packed {
        logic [30:0]                    radius;
        logic [30:0]                    height;
        logic [2:0][COORD_W-1:0]        center;
        logic [2:0][AXIS_W-1:0]         axis;
    } cfg_t;

    // Direction as sign and magnitude per component.
    typedef struct packed {
        logic [2:0]                     neg;
        logic [2:0][COORD_W-1:0]        mag;
    } dir_t;

    // Unit direction, 30 fraction bits, sign and magnitude.
    typedef struct packed {
        logic [2:0]                     neg;
        logic [2:0][UMAG_W-1:0]         umag;
    } unit_t;

    // Count of leading zeros of a 32-bit word; 32 for zero.
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csp_if.sv =====
// ============================================================================
// csp_if
// Valid/ready stream interfaces for direction queries and support points.
// ============================================================================
`default_nettype none

interface csp_dir_if;
    import csp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  dir_x;
    logic signed [COORD_W-1:0]  dir_y;
    logic signed [COORD_W-1:0]  dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface csp_point_if;
    import csp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/csp_cfg.sv =====
// ============================================================================
// csp_cfg
// APB register file holding radius, cylinder height, centre and axis.
// ============================================================================
`default_nettype none

module csp_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [csp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [csp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output csp_pkg::cfg_t                       cfg
);
    import csp_pkg::*;

    // Reset shape: everything zero except a unit axis along x.
    localparam cfg_t CFG_RESET = '{
        radius: '0,
        height: '0,
        center: '0,
        axis:   {AXIS_W'(0), AXIS_W'(0), AXIS_W'(1 << AXIS_BITS)}
    };

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_RADIUS:   cfg_next.radius    = pwdata[30:0];
                REG_HEIGHT:   cfg_next.height    = pwdata[30:0];
                REG_CENTER_X: cfg_next.center[0] = pwdata;
                REG_CENTER_Y: cfg_next.center[1] = pwdata;
                REG_CENTER_Z: cfg_next.center[2] = pwdata;
                REG_AXIS_X:   cfg_next.axis[0]   = pwdata[AXIS_W-1:0];
                REG_AXIS_Y:   cfg_next.axis[1]   = pwdata[AXIS_W-1:0];
                REG_AXIS_Z:   cfg_next.axis[2]   = pwdata[AXIS_W-1:0];
                default:      cfg_next           = cfg_reg;
            endcase
        end
    end

    // Register read mux; the axis reads back sign-extended.
    always_comb
    begin
        case (idx)
            REG_RADIUS:   prdata = {1'b0, cfg_reg.radius};
            REG_HEIGHT:   prdata = {1'b0, cfg_reg.height};
            REG_CENTER_X: prdata = cfg_reg.center[0];
            REG_CENTER_Y: prdata = cfg_reg.center[1];
            REG_CENTER_Z: prdata = cfg_reg.center[2];
            REG_AXIS_X:   prdata = {{(APB_DATA_W-AXIS_W){cfg_reg.axis[0][AXIS_W-1]}},
                                    cfg_reg.axis[0]};
            REG_AXIS_Y:   prdata = {{(APB_DATA_W-AXIS_W){cfg_reg.axis[1][AXIS_W-1]}},
                                    cfg_reg.axis[1]};
            REG_AXIS_Z:   prdata = {{(APB_DATA_W-AXIS_W){cfg_reg.axis[2][AXIS_W-1]}},
                                    cfg_reg.axis[2]};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/csp_front.sv =====
// ============================================================================
// csp_front
// Direction front end: sign/magnitude split, normalising shift and the sum of
// squares, in five register stages.
// ============================================================================
`default_nettype none

module csp_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [2:0][csp_pkg::COORD_W-1:0]  in_dir,
    output logic                                   out_valid,
    output csp_pkg::dir_t                          out_dir,
    output logic [2*csp_pkg::COORD_W-1:0]          out_sum
);
    import csp_pkg::*;

    localparam int SQ_W = 2 * COORD_W;

    // Stage 1: magnitudes and largest magnitude.
    logic                v1_reg;
    dir_t                d1_reg, d1_next;
    logic [COORD_W-1:0]  m1_reg, m1_next;

    always_comb
    begin
        m1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            d1_next.neg[i] = in_dir[i][COORD_W-1];
            d1_next.mag[i] = in_dir[i][COORD_W-1] ? (~in_dir[i] + COORD_W'(1)) : in_dir[i];
            if (d1_next.mag[i] > m1_next)
            begin
                m1_next = d1_next.mag[i];
            end
        end
        // A zero direction becomes the unit x vector.
        if (m1_next == '0)
        begin
            d1_next.mag[0] = COORD_W'(1) << FRACTION_BITS;
            m1_next        = COORD_W'(1) << FRACTION_BITS;
        end
    end

    // Stage 2: shift that brings the largest magnitude to at least 2^30.
    logic        v2_reg;
    dir_t        d2_reg;
    logic [4:0]  k2_reg, k2_next;
    logic [5:0]  lz;

    always_comb
    begin
        lz      = lzc32(m1_reg);
        k2_next = (lz == 6'd0) ? 5'd0 : 5'(lz - 6'd1);
    end

    // Stage 3: apply the shift.
    logic  v3_reg;
    dir_t  d3_reg, d3_next;

    always_comb
    begin
        d3_next.neg = d2_reg.neg;
        for (int i = 0; i < 3; i++)
        begin
            d3_next.mag[i] = d2_reg.mag[i] << k2_reg;
        end
    end

    // Stage 4: squares.
    logic            v4_reg;
    dir_t            d4_reg;
    logic [SQ_W-1:0] sq4_reg [3];

    // Stage 5: sum of squares.
    logic            v5_reg;
    dir_t            d5_reg;
    logic [SQ_W-1:0] sum5_reg, sum5_next;

    assign sum5_next = sq4_reg[0] + sq4_reg[1] + sq4_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= d1_next;
            m1_reg   <= m1_next;
            d2_reg   <= d1_reg;
            k2_reg   <= k2_next;
            d3_reg   <= d3_next;
            d4_reg   <= d3_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq4_reg[i] <= SQ_W'(d3_reg.mag[i]) * SQ_W'(d3_reg.mag[i]);
            end
            d5_reg   <= d4_reg;
            sum5_reg <= sum5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_dir   = d5_reg;
    assign out_sum   = sum5_reg;

endmodule

`default_nettype wire

// ===== rtl/core/csp_sqrt.sv =====
// ============================================================================
// csp_sqrt
// Pipelined integer square root of the 64-bit sum of squares, one result bit
// per register stage.
// ============================================================================
`default_nettype none

module csp_sqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [2*csp_pkg::LEN_W-1:0]     in_sum,
    input  wire csp_pkg::dir_t                   in_dir,
    output logic                                 out_valid,
    output logic [csp_pkg::LEN_W-1:0]            out_len,
    output csp_pkg::dir_t                        out_dir
);
    import csp_pkg::*;

    localparam int S_W   = 2 * LEN_W;
    localparam int REM_W = LEN_W + 4;

    logic             v_reg   [SQRT_STEPS];
    logic [REM_W-1:0] rem_reg [SQRT_STEPS];
    logic [LEN_W-1:0] q_reg   [SQRT_STEPS];
    logic [S_W-1:0]   s_reg   [SQRT_STEPS];
    dir_t             d_reg   [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic             v_p;
        logic [REM_W-1:0] rem_p, rem_t, trial, rem_next;
        logic [LEN_W-1:0] q_p, q_next;
        logic [S_W-1:0]   s_p;
        dir_t             d_p;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign v_p   = in_valid;
            assign rem_p = '0;
            assign q_p   = '0;
            assign s_p   = in_sum;
            assign d_p   = in_dir;
        end
        else
        begin : g_next
            assign v_p   = v_reg[j-1];
            assign rem_p = rem_reg[j-1];
            assign q_p   = q_reg[j-1];
            assign s_p   = s_reg[j-1];
            assign d_p   = d_reg[j-1];
        end

        // Bring down the next two bits and try the next root bit.
        always_comb
        begin
            rem_t    = {rem_p[REM_W-3:0], s_p[S_W-1 -: 2]};
            trial    = {2'b00, q_p, 2'b01};
            ge       = (rem_t >= trial);
            rem_next = ge ? (rem_t - trial) : rem_t;
            q_next   = {q_p[LEN_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                s_reg[j]   <= {s_p[S_W-3:0], 2'b00};
                d_reg[j]   <= d_p;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_len   = q_reg[SQRT_STEPS-1];
    assign out_dir   = d_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/csp_div.sv =====
// ============================================================================
// csp_div
// Three-lane pipelined divider forming the rounded unit direction,
// mag * 2^30 / length, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module csp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [csp_pkg::LEN_W-1:0]   in_len,
    input  wire csp_pkg::dir_t               in_dir,
    output logic                             out_valid,
    output csp_pkg::unit_t                   out_unit
);
    import csp_pkg::*;

    localparam int N_W  = COORD_W + UNIT_BITS;
    localparam int NL_W = DIV_STEPS;

    // Prep stage: dividend with half the divisor added for rounding.
    logic              pv_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [2:0]        pneg_reg;
    logic [LEN_W-1:0]  pr_reg  [3];
    logic [NL_W-1:0]   pnl_reg [3];
    logic [N_W-1:0]    num     [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {in_dir.mag[i], UNIT_BITS'(0)} + N_W'(in_len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plen_reg <= in_len;
            pneg_reg <= in_dir.neg;
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i]  <= LEN_W'(num[i][N_W-1:NL_W]);
                pnl_reg[i] <= num[i][NL_W-1:0];
            end
        end
    end

    // Long division stages.
    logic              v_reg   [DIV_STEPS];
    logic [LEN_W-1:0]  len_reg [DIV_STEPS];
    logic [2:0]        neg_reg [DIV_STEPS];
    logic [LEN_W-1:0]  r_reg   [DIV_STEPS][3];
    logic [NL_W-1:0]   nl_reg  [DIV_STEPS][3];
    logic [UMAG_W-1:0] q_reg   [DIV_STEPS][3];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        logic              v_p;
        logic [LEN_W-1:0]  len_p;
        logic [2:0]        neg_p;
        logic [LEN_W-1:0]  r_p  [3];
        logic [NL_W-1:0]   nl_p [3];
        logic [UMAG_W-1:0] q_p  [3];
        logic [LEN_W:0]    t    [3];
        logic [LEN_W-1:0]  r_next [3];
        logic [UMAG_W-1:0] q_next [3];
        logic [2:0]        ge;

        if (j == 0)
        begin : g_first
            assign v_p   = pv_reg;
            assign len_p = plen_reg;
            assign neg_p = pneg_reg;
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_p[i]  = pr_reg[i];
                    nl_p[i] = pnl_reg[i];
                    q_p[i]  = '0;
                end
            end
        end
        else
        begin : g_next
            assign v_p   = v_reg[j-1];
            assign len_p = len_reg[j-1];
            assign neg_p = neg_reg[j-1];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_p[i]  = r_reg[j-1][i];
                    nl_p[i] = nl_reg[j-1][i];
                    q_p[i]  = q_reg[j-1][i];
                end
            end
        end

        // Shift in the next dividend bit and subtract the divisor if it fits.
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i]      = {r_p[i], nl_p[i][NL_W-1]};
                ge[i]     = (t[i] >= {1'b0, len_p});
                r_next[i] = ge[i] ? LEN_W'(t[i] - {1'b0, len_p}) : t[i][LEN_W-1:0];
                q_next[i] = {q_p[i][UMAG_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[j] <= len_p;
                neg_reg[j] <= neg_p;
                for (int i = 0; i < 3; i++)
                begin
                    r_reg[j][i]  <= r_next[i];
                    nl_reg[j][i] <= {nl_p[i][NL_W-2:0], 1'b0};
                    q_reg[j][i]  <= q_next[i];
                end
            end
        end
    end

    assign out_valid    = v_reg[DIV_STEPS-1];
    assign out_unit.neg = neg_reg[DIV_STEPS-1];

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign out_unit.umag[i] = q_reg[DIV_STEPS-1][i];
    end

endmodule

`default_nettype wire

// ===== rtl/core/csp_back.sv =====
// ============================================================================
// csp_back
// Back end: radius push and half-axis shift, exact choice of the end sphere,
// candidate sum and saturation, in six register stages.
// ============================================================================
`default_nettype none

module csp_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire csp_pkg::cfg_t                     cfg,
    input  wire logic                              in_valid,
    input  wire csp_pkg::unit_t                    in_unit,
    output logic                                   out_valid,
    output logic [2:0][csp_pkg::COORD_W-1:0]       out_point
);
    import csp_pkg::*;

    localparam int PR_W = 31 + UMAG_W;
    localparam int SH_W = AXIS_W + 32;
    localparam int PD_W = 2 * SR_W;
    localparam int DS_W = PD_W + 2;
    localparam int PT_W = COORD_W + 3;

    // Stage 1: products radius * |u| and axis * height.
    logic                   v1_reg;
    logic [2:0]             neg1_reg;
    logic [PR_W-1:0]        pr1_reg [3];
    logic signed [SH_W-1:0] sh1_reg [3];

    // Stage 2: rounding to r and s.
    logic                   v2_reg;
    logic signed [SR_W-1:0] r2_reg [3], r2_next [3];
    logic signed [SR_W-1:0] s2_reg [3], s2_next [3];
    logic [PR_W-1:0]        rsum   [3];
    logic [SR_W-1:0]        rmag   [3];
    logic [SH_W-1:0]        shmag  [3];
    logic [SR_W-1:0]        smag   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum[i]    = pr1_reg[i] + (PR_W'(1) << (UNIT_BITS - 1));
            rmag[i]    = SR_W'(rsum[i] >> UNIT_BITS);
            r2_next[i] = neg1_reg[i] ? $signed(~rmag[i] + SR_W'(1)) : $signed(rmag[i]);
            shmag[i]   = sh1_reg[i][SH_W-1] ? SH_W'(-sh1_reg[i]) : SH_W'(sh1_reg[i]);
            smag[i]    = SR_W'((shmag[i] + (SH_W'(1) << AXIS_BITS)) >> (AXIS_BITS + 1));
            s2_next[i] = sh1_reg[i][SH_W-1] ? $signed(~smag[i] + SR_W'(1)) : $signed(smag[i]);
        end
    end

    // Stage 3: dot product terms s * r.
    logic                   v3_reg;
    logic signed [SR_W-1:0] r3_reg [3], s3_reg [3];
    logic signed [PD_W-1:0] pd3_reg [3];

    // Stage 4: the first candidate wins only when s . r is positive.
    logic                   v4_reg;
    logic signed [SR_W-1:0] r4_reg [3], s4_reg [3];
    logic                   first4_reg, first4_next;
    logic signed [DS_W-1:0] dsum;

    always_comb
    begin
        dsum        = DS_W'(pd3_reg[0]) + DS_W'(pd3_reg[1]) + DS_W'(pd3_reg[2]);
        first4_next = (dsum > DS_W'(0));
    end

    // Stage 5: candidate point at full width.
    logic                   v5_reg;
    logic signed [PT_W-1:0] pt5_reg [3], pt5_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt5_next[i] = $signed(cfg.center[i])
                        + (first4_reg ? PT_W'(s4_reg[i]) : -PT_W'(s4_reg[i]))
                        + PT_W'(r4_reg[i]);
        end
    end

    // Stage 6: saturation into the output register.
    logic                          v6_reg;
    logic [2:0][COORD_W-1:0]       pt6_reg, pt6_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!pt5_reg[i][PT_W-1] && (pt5_reg[i][PT_W-2:COORD_W-1] != '0))
            begin
                pt6_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
            else if (pt5_reg[i][PT_W-1] && (pt5_reg[i][PT_W-2:COORD_W-1] != '1))
            begin
                pt6_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                pt6_next[i] = pt5_reg[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg   <= in_unit.neg;
            for (int i = 0; i < 3; i++)
            begin
                pr1_reg[i] <= PR_W'(cfg.radius) * PR_W'(in_unit.umag[i]);
                sh1_reg[i] <= $signed(cfg.axis[i]) * $signed({1'b0, cfg.height});
                r2_reg[i]  <= r2_next[i];
                s2_reg[i]  <= s2_next[i];
                r3_reg[i]  <= r2_reg[i];
                s3_reg[i]  <= s2_reg[i];
                pd3_reg[i] <= s2_reg[i] * r2_reg[i];
                r4_reg[i]  <= r3_reg[i];
                s4_reg[i]  <= s3_reg[i];
                pt5_reg[i] <= pt5_next[i];
            end
            first4_reg <= first4_next;
            pt6_reg    <= pt6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_point = pt6_reg;

endmodule

`default_nettype wire

// ===== rtl/core/capsule_support_point.sv =====
// ============================================================================
// capsule_support_point
// Capsule support mapping for GJK: returns the farthest surface point of a
// configured capsule along each query direction.
// ============================================================================
// Takes one query direction per clock and returns one support point per
// query, in order, after it has passed through the pipeline (5 front-end
// stages, 32 square-root stages, 32 divider stages made of one rounding
// set-up stage and 31 quotient stages, and 6 back-end stages; the square root
// and each quotient gain one result bit per stage). The whole pipeline
// advances together: while a finished point waits on the output, every stage
// holds and no new query is taken; otherwise a beat enters every cycle.
// Registers are written over APB and must only change while no query is in
// flight. All coordinates are signed Q16.16 and the result saturates.
`default_nettype none

module capsule_support_point (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    csp_dir_if.sink                             query,
    csp_point_if.source                         support,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [csp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [csp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import csp_pkg::*;

    cfg_t                    cfg;
    logic                    en;
    logic [2:0][COORD_W-1:0] dir;

    logic                    front_valid;
    dir_t                    front_dir;
    logic [2*LEN_W-1:0]      front_sum;

    logic                    sqrt_valid;
    logic [LEN_W-1:0]        sqrt_len;
    dir_t                    sqrt_dir;

    logic                    div_valid;
    unit_t                   div_unit;

    logic                    back_valid;
    logic [2:0][COORD_W-1:0] back_point;

    // Global advance: move on unless a point is waiting on a stalled sink.
    assign en          = !back_valid || support.ready;
    assign query.ready = en;

    assign dir = {query.dir_z, query.dir_y, query.dir_x};

    csp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query.valid),
        .in_dir    (dir),
        .out_valid (front_valid),
        .out_dir   (front_dir),
        .out_sum   (front_sum)
    );

    csp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_sum    (front_sum),
        .in_dir    (front_dir),
        .out_valid (sqrt_valid),
        .out_len   (sqrt_len),
        .out_dir   (sqrt_dir)
    );

    csp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_len    (sqrt_len),
        .in_dir    (sqrt_dir),
        .out_valid (div_valid),
        .out_unit  (div_unit)
    );

    csp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .in_unit   (div_unit),
        .out_valid (back_valid),
        .out_point (back_point)
    );

    assign support.valid   = back_valid;
    assign support.point_x = back_point[0];
    assign support.point_y = back_point[1];
    assign support.point_z = back_point[2];

endmodule

`default_nettype wire

// ===== sim/capsule_support_point_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// capsule_support_point_tb
// Self-checking bench for the capsule support point pipeline.
// ============================================================================
// Queries are driven on the valid/ready input stream. Each accepted beat is
// run through a bit-exact support mapping in the bench, and the result is
// queued. Output beats are compared field by field with the oldest queued
// point. The capsule shape is reprogrammed over APB between phases, while
// nothing is in flight. Both stream sides idle at random, and the receiver
// holds off once for a long stretch so that the pipeline fills and stalls.
// ============================================================================

module capsule_support_point_tb;
    import csp_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    csp_dir_if   query_if ();
    csp_point_if support_if ();

    capsule_support_point uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_if.sink),
        .support (support_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bench copy of the capsule shape.
    longint shape_radius;
    longint shape_height;
    longint shape_center [3];
    longint shape_axis [3];

    point_t pending_points [$];
    int     fail_count;
    bit     sender_quiet;
    bit     receiver_quiet;
    int     hold_req;
    int     hold_ack;
    int     hold_left;
    int     stall_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Magnitude of a signed 64-bit value.
    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // Division by 2^n, rounded half away from zero.
    function automatic longint round_shift(longint v, int n);
        longint unsigned m;
        m = (mag64(v) + (64'd1 << (n - 1))) >> n;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

    // Support point of the configured capsule along one direction.
    function automatic point_t support_of(logic signed [COORD_W-1:0] dx,
                                         logic signed [COORD_W-1:0] dy,
                                         logic signed [COORD_W-1:0] dz);
        longint          c [3];
        longint          r [3];
        longint          s [3];
        longint          p [3];
        longint unsigned peak;
        longint unsigned sumsq;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned quo;
        longint          dot;
        bit              take_first;
        point_t          pt;
        c[0] = dx;
        c[1] = dy;
        c[2] = dz;
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (mag64(c[i]) > peak)
            begin
                peak = mag64(c[i]);
            end
        end
        // A zero direction becomes the unit x vector.
        if (peak == 0)
        begin
            c[0] = longint'(1) << FRACTION_BITS;
            peak = c[0];
        end
        while (peak < (64'd1 << UNIT_BITS))
        begin
            peak = peak << 1;
            for (int i = 0; i < 3; i++)
            begin
                c[i] = c[i] * 2;
            end
        end
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            sumsq += mag64(c[i]) * mag64(c[i]);
        end
        // Integer square root, two bits per step.
        rem   = sumsq;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        // Unit direction, push vector and half-axis shift.
        for (int i = 0; i < 3; i++)
        begin
            quo  = ((mag64(c[i]) << UNIT_BITS) + (root >> 1)) / root;
            r[i] = round_shift(shape_radius * ((c[i] < 0) ? -longint'(quo) : longint'(quo)),
                               UNIT_BITS);
            s[i] = round_shift(shape_axis[i] * shape_height, AXIS_BITS + 1);
        end
        // Ties go to the centre-minus-shift candidate.
        dot        = s[0] * r[0] + s[1] * r[1];
        take_first = dot > -(s[2] * r[2]);
        for (int i = 0; i < 3; i++)
        begin
            p[i] = take_first ? shape_center[i] + s[i] + r[i]
                              : shape_center[i] - s[i] + r[i];
        end
        pt.x = clamp_coord(p[0]);
        pt.y = clamp_coord(p[1]);
        pt.z = clamp_coord(p[2]);
        return pt;
    endfunction

    // One APB register write: setup cycle, then access cycle.
    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIUS:   shape_radius    = value[30:0];
            REG_HEIGHT:   shape_height    = value[30:0];
            REG_CENTER_X: shape_center[0] = longint'($signed(value));
            REG_CENTER_Y: shape_center[1] = longint'($signed(value));
            REG_CENTER_Z: shape_center[2] = longint'($signed(value));
            REG_AXIS_X:   shape_axis[0]   = longint'($signed(value[15:0]));
            REG_AXIS_Y:   shape_axis[1]   = longint'($signed(value[15:0]));
            REG_AXIS_Z:   shape_axis[2]   = longint'($signed(value[15:0]));
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_shape(logic [30:0] rad, logic [30:0] hgt,
                               logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        write_reg(REG_RADIUS, {1'b0, rad});
        write_reg(REG_HEIGHT, {1'b0, hgt});
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_AXIS_X, {{16{ax[15]}}, ax});
        write_reg(REG_AXIS_Y, {{16{ay[15]}}, ay});
        write_reg(REG_AXIS_Z, {{16{az[15]}}, az});
    endtask

    // Sends one query beat and queues its expected support point.
    task automatic send_query(logic signed [COORD_W-1:0] dx,
                              logic signed [COORD_W-1:0] dy,
                              logic signed [COORD_W-1:0] dz);
        if (!sender_quiet && $urandom_range(99) < IDLE_PCT)
        begin
            query_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
            begin
                @(posedge clk);
            end
        end
        query_if.valid <= 1'b1;
        query_if.dir_x <= dx;
        query_if.dir_y <= dy;
        query_if.dir_z <= dz;
        @(posedge clk);
        while (!query_if.ready)
        begin
            @(posedge clk);
        end
        pending_points.push_back(support_of(dx, dy, dz));
    endtask

    // Lowers valid and waits until every queued point has been checked.
    task automatic drain;
        query_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($urandom_range(65536 * 4)) - 32'd131072;
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [15:0] rand_axis();
        return 16'($urandom_range(32768)) - 16'd16384;
    endfunction

    task automatic random_shape;
        write_shape($urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1 << 22)),
                    $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(1 << 22)),
                    rand_coord(), rand_coord(), rand_coord(),
                    rand_axis(), rand_axis(), rand_axis());
    endtask

    task automatic random_queries(int count);
        logic signed [COORD_W-1:0] d [3];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d[i] = ($urandom_range(9) == 0) ? 32'sd0 : $signed(rand_coord());
            end
            if ($urandom_range(49) == 0)
            begin
                d[0] = 0;
                d[1] = 0;
                d[2] = 0;
            end
            send_query(d[0], d[1], d[2]);
        end
    endtask

    // Reset shape: zero radius and height give ties; extreme and zero
    // directions exercise the normalisation.
    task automatic test_reset_shape;
        send_query(0, 0, 0);
        send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_query(1, 0, 0);
        send_query(0, -1, 0);
        send_query(0, 0, 32'sh0001_0000);
        drain();
    endtask

    // Extreme shapes: saturation, ties with the direction across the axis,
    // and an axis beyond unit length.
    task automatic test_extreme_shapes;
        write_shape(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                    16'sd16384, 16'sd0, 16'sd0);
        send_query(32'sh7FFF_FFFF, 0, 0);
        send_query(32'sh8000_0000, 0, 0);
        send_query(0, 32'sh7FFF_FFFF, 0);
        send_query(0, 0, 32'sh8000_0000);
        send_query(0, 0, 0);
        send_query(-1, -1, -1);
        drain();
        write_shape(31'h0001_0000, 31'h0004_0000, 32'h0, 32'h0, 32'h0,
                    -16'sd16384, 16'sd16384, -16'sd16384);
        send_query(32'sh0001_0000, 32'sh0001_0000, 0);
        send_query(1, 1, 1);
        send_query(-5, 3, 7);
        send_query(0, 0, 0);
        send_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        drain();
        write_shape(31'h0, 31'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    16'sd0, 16'sd0, 16'sd0);
        send_query(32'sh0000_8000, 32'sh8000_0000, 1);
        send_query(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0003);
        drain();
    endtask

    // Random shapes and queries, one phase with no idling on either side.
    task automatic test_random_phases;
        for (int ph = 0; ph < 5; ph++)
        begin
            random_shape();
            sender_quiet   = (ph == 2);
            receiver_quiet = (ph == 2);
            random_queries(230);
            drain();
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // Long receiver hold-off while queries keep coming.
    task automatic test_backpressure;
        random_shape();
        hold_req++;
        sender_quiet = 1'b1;
        random_queries(100);
        sender_quiet = 1'b0;
        drain();
    endtask

    // Receiver: random ready, plus the long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack          <= hold_req;
            hold_left         <= HOLD_CYCLES;
            support_if.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left        <= hold_left - 1;
            support_if.ready <= 1'b0;
        end
        else
        begin
            support_if.ready <= receiver_quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Output checker.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && support_if.valid && support_if.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time,
                         support_if.point_x, support_if.point_y, support_if.point_z);
                fail_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (support_if.point_x !== want.x)
                begin
                    $display("%0t: point_x expected %0d actual %0d", $time,
                             want.x, support_if.point_x);
                    fail_count++;
                end
                if (support_if.point_y !== want.y)
                begin
                    $display("%0t: point_y expected %0d actual %0d", $time,
                             want.y, support_if.point_y);
                    fail_count++;
                end
                if (support_if.point_z !== want.z)
                begin
                    $display("%0t: point_z expected %0d actual %0d", $time,
                             want.z, support_if.point_z);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either stream.
    always @(posedge clk)
    begin
        if ((query_if.valid && query_if.ready) || (support_if.valid && support_if.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        query_if.valid   = 1'b0;
        query_if.dir_x   = '0;
        query_if.dir_y   = '0;
        query_if.dir_z   = '0;
        support_if.ready = 1'b0;
        fail_count       = 0;
        sender_quiet     = 1'b0;
        receiver_quiet   = 1'b0;
        hold_req         = 0;
        hold_ack         = 0;
        hold_left        = 0;
        stall_cycles     = 0;
        shape_radius     = 0;
        shape_height     = 0;
        shape_center     = '{0, 0, 0};
        shape_axis       = '{16384, 0, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_shape();
        test_extreme_shapes();
        test_random_phases();
        test_backpressure();

        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
